[rtl/mtg_pkg.sv]
// ----------------------------------------------------------------------------
// mtg_pkg
// Types, constants and helper functions shared by the Mersenne Twister
// generator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mtg_pkg;

  localparam int StateWords = 624;
  localparam int ShiftSpan  = 397;
  localparam int IdxW       = $clog2(StateWords + 2);
  localparam int WordW      = 32;

  localparam logic [WordW-1:0] LcgMult     = 32'h0001_0DCD;
  localparam logic [WordW-1:0] TwistMatrix = 32'h9908_B0DF;
  localparam logic [WordW-1:0] TemperB     = 32'h9D2C_5680;
  localparam logic [WordW-1:0] TemperC     = 32'hEFC6_0000;
  localparam logic [WordW-1:0] DefaultSeed = 32'h0000_1105;

  // Read position codes outside the drawing range.
  localparam logic [IdxW-1:0] PosTwistDue   = IdxW'(StateWords);
  localparam logic [IdxW-1:0] PosNeverSeeded = IdxW'(StateWords + 1);

  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [WordW-1:0] word_t;

  // Requests from the sequencer to the state table.
  typedef struct packed {
    logic  we;
    idx_t  waddr;
    word_t wdata;
    logic  re;
    idx_t  raddr_a;
    idx_t  raddr_b;
  } mem_req_t;

  // Controls of the shared congruential unit.
  typedef struct packed {
    logic  load;
    logic  step;
    word_t seed;
  } lcg_ctl_t;

  function automatic word_t twist_word(word_t cur, word_t nxt, word_t far);
    word_t y;
    word_t v;
    y = {cur[WordW-1], nxt[WordW-2:0]};
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TwistMatrix;
    end
    return v;
  endfunction

  function automatic word_t temper(word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

`default_nettype wire

[rtl/mtg_state_mem.sv]
// ----------------------------------------------------------------------------
// mtg_state_mem
// State table: one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module mtg_state_mem import mtg_pkg::*; (
  input  wire logic     clk,
  input  wire mem_req_t req,
  output      word_t    rd_a,
  output      word_t    rd_b
);

  word_t mem [StateWords];
  word_t rd_a_r;
  word_t rd_b_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_a_r <= mem[req.raddr_a];
      rd_b_r <= mem[req.raddr_b];
    end
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

`default_nettype wire

[rtl/mtg_lcg_unit.sv]
// ----------------------------------------------------------------------------
// mtg_lcg_unit
// Shared congruential step x <- 69069 * x + 1, one step per cycle while ctl.step is set.
// ----------------------------------------------------------------------------
`default_nettype none

module mtg_lcg_unit import mtg_pkg::*; (
  input  wire logic     clk,
  input  wire lcg_ctl_t ctl,
  output      word_t    x
);

  word_t x_r;
  word_t x_nxt;
  word_t prod;

  assign prod = x_r * LcgMult;

  always_comb begin
    x_nxt = x_r;
    if (ctl.load) begin
      x_nxt = ctl.seed;
    end else if (ctl.step) begin
      x_nxt = prod + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
  end

  assign x = x_r;

endmodule

`default_nettype wire

[rtl/mersenne_twister_generator.sv]
// ----------------------------------------------------------------------------
// mersenne_twister_generator
// MT19937 generator with the original congruential seeding.
// ----------------------------------------------------------------------------
// Input beats carry in_func and in_seed_value. A seed beat (in_func = 0)
// reloads all 624 table words and gives no result. A draw beat (in_func = 1)
// gives one tempered word on the out_ channel.
// The table sits in one memory with two read ports; seeding computes every
// table word with the single congruential multiplier. A beat runs through
// these states:
//   seed beat:          S_SEED_A and S_SEED_B for each word, then idle
//   draw, words left:   S_DRAW_RD, then S_DRAW_OUT, then idle
//   draw, table used:   twist (S_TW_PRE, S_TW_CUR, S_TW_RD, S_TW_WR), then draw
//   first draw after reset without a seed: the table is seeded with 4357
//   first, then twisted, then drawn.
// in_stall is high while a beat is being worked on. A finished result waits
// in the output register while out_stall is high; the next beat is taken
// meanwhile, and a second draw waits for that register to empty.
// Reset marks the generator as never seeded; the table is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module mersenne_twister_generator import mtg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic        in_func,
  input  wire logic [31:0] in_seed_value,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [31:0] out_random_word
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SEED_A   = 9'b000000010,
    S_SEED_B   = 9'b000000100,
    S_TW_PRE   = 9'b000001000,
    S_TW_CUR   = 9'b000010000,
    S_TW_RD    = 9'b000100000,
    S_TW_WR    = 9'b001000000,
    S_DRAW_RD  = 9'b010000000,
    S_DRAW_OUT = 9'b100000000
  } state_t;

  state_t   state_r, state_nxt;
  idx_t     pos_r, pos_nxt;
  idx_t     idx_r, idx_nxt;
  logic     seed_only_r, seed_only_nxt;
  logic [15:0] hi_r, hi_nxt;
  word_t    cur_r, cur_nxt;
  logic     out_valid_r, out_valid_nxt;
  word_t    out_word_r, out_word_nxt;

  mem_req_t mem_req;
  lcg_ctl_t lcg_ctl;
  word_t    rd_a, rd_b;
  word_t    lcg_x;

  idx_t        idx_next_wrap;
  logic [IdxW:0] far_sum;
  idx_t        idx_far;
  logic        out_free;
  logic        in_acc;

  mtg_state_mem u_mem (
    .clk  (clk),
    .req  (mem_req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  mtg_lcg_unit u_lcg (
    .clk (clk),
    .ctl (lcg_ctl),
    .x   (lcg_x)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_random_word = out_word_r;

  assign idx_next_wrap = (idx_r == idx_t'(StateWords - 1)) ? '0 : idx_r + idx_t'(1);
  assign far_sum = {1'b0, idx_r} + (IdxW+1)'(ShiftSpan);
  assign idx_far = (far_sum >= (IdxW+1)'(StateWords))
                 ? idx_t'(far_sum - (IdxW+1)'(StateWords)) : far_sum[IdxW-1:0];

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    seed_only_nxt = seed_only_r;
    hi_nxt        = hi_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    mem_req       = '0;
    lcg_ctl       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          idx_nxt = '0;
          if (!in_func) begin
            lcg_ctl.load  = 1'b1;
            lcg_ctl.seed  = in_seed_value;
            seed_only_nxt = 1'b1;
            state_nxt     = S_SEED_A;
          end else if (pos_r == PosNeverSeeded) begin
            lcg_ctl.load  = 1'b1;
            lcg_ctl.seed  = DefaultSeed;
            seed_only_nxt = 1'b0;
            state_nxt     = S_SEED_A;
          end else if (pos_r == PosTwistDue) begin
            state_nxt = S_TW_PRE;
          end else begin
            state_nxt = S_DRAW_RD;
          end
        end
      end
      S_SEED_A: begin
        hi_nxt       = lcg_x[31:16];
        lcg_ctl.step = 1'b1;
        state_nxt    = S_SEED_B;
      end
      S_SEED_B: begin
        // The lower half comes from the upper half of the following value.
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r;
        mem_req.wdata = {hi_r, lcg_x[31:16]};
        lcg_ctl.step  = 1'b1;
        idx_nxt       = idx_next_wrap;
        if (idx_r == idx_t'(StateWords - 1)) begin
          pos_nxt   = PosTwistDue;
          state_nxt = seed_only_r ? S_IDLE : S_TW_PRE;
        end else begin
          state_nxt = S_SEED_A;
        end
      end
      S_TW_PRE: begin
        mem_req.re      = 1'b1;
        mem_req.raddr_a = '0;
        mem_req.raddr_b = '0;
        idx_nxt         = '0;
        state_nxt       = S_TW_CUR;
      end
      S_TW_CUR: begin
        cur_nxt   = rd_a;
        state_nxt = S_TW_RD;
      end
      S_TW_RD: begin
        mem_req.re      = 1'b1;
        mem_req.raddr_a = idx_next_wrap;
        mem_req.raddr_b = idx_far;
        state_nxt       = S_TW_WR;
      end
      S_TW_WR: begin
        // The word read at i+1 becomes the current word of the next step.
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r;
        mem_req.wdata = twist_word(cur_r, rd_a, rd_b);
        cur_nxt       = rd_a;
        idx_nxt       = idx_next_wrap;
        if (idx_r == idx_t'(StateWords - 1)) begin
          pos_nxt   = '0;
          state_nxt = S_DRAW_RD;
        end else begin
          state_nxt = S_TW_RD;
        end
      end
      S_DRAW_RD: begin
        mem_req.re      = 1'b1;
        mem_req.raddr_a = pos_r;
        mem_req.raddr_b = pos_r;
        state_nxt       = S_DRAW_OUT;
      end
      S_DRAW_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = temper(rd_a);
          pos_nxt       = pos_r + idx_t'(1);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= PosNeverSeeded;
      out_valid_r <= 1'b0;
      seed_only_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      seed_only_r <= seed_only_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r       <= hi_nxt;
    cur_r      <= cur_nxt;
    out_word_r <= out_word_nxt;
  end

  // The read position never leaves the range of its defined codes.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PosNeverSeeded)
    else $error("read position out of range");

  // The table is written only while seeding or twisting.
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (state_r == S_SEED_B || state_r == S_TW_WR))
    else $error("table write outside seed or twist");

  // A word is drawn only from a valid table position.
  a_draw_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAW_RD) |-> (pos_r < PosTwistDue))
    else $error("draw from an exhausted table");

  // A twist starts only when the table has been used up or just seeded.
  a_twist_due: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TW_PRE) |-> (pos_r == PosTwistDue))
    else $error("twist started with words left");

  // A result is never overwritten while the receiver holds it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && state_r == S_DRAW_OUT) |=> (state_r == S_DRAW_OUT))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

[verif/mtg_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mtg_tb_pkg
// Codes shared by the stimulus and the checker of the Mersenne Twister
// generator testbench.
// ----------------------------------------------------------------------------

package mtg_tb_pkg;

  typedef enum logic {
    FuncSeed = 1'b0,
    FuncDraw = 1'b1
  } mt_func_t;

endpackage

[verif/mtg_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mtg_checker
// Scoreboard for the Mersenne Twister generator. It keeps its own copy of
// the state table, updates it from every accepted input beat, and compares
// each accepted output beat with the oldest predicted word.
// ----------------------------------------------------------------------------

module mtg_checker
  import mtg_pkg::*;
  import mtg_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_func,
  input  logic [31:0] in_seed_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_random_word,
  output int          fail_count,
  output int          words_pending
);

  localparam int Unseeded      = StateWords + 1;
  localparam int ShownFailures = 10;

  word_t mt_words [StateWords];
  int    next_word;
  word_t predicted_words [$];
  int    failures;
  int    results_seen;

  function automatic word_t lcg_advance(word_t x);
    return x * LcgMult + 32'd1;
  endfunction

  // Each table word takes its upper half from the current congruential value
  // and its lower half from the upper half of the following one.
  function automatic void fill_table(word_t seed);
    word_t x;
    word_t nx;
    int    i;
    x = seed;
    for (i = 0; i < StateWords; i++) begin
      nx = lcg_advance(x);
      mt_words[i] = {x[31:16], nx[31:16]};
      x = lcg_advance(nx);
    end
    next_word = StateWords;
  endfunction

  // The twist runs in place, so late words already see regenerated neighbors.
  function automatic void regenerate_table();
    word_t mixed;
    word_t fresh;
    int    i;
    for (i = 0; i < StateWords; i++) begin
      mixed = {mt_words[i][31], mt_words[(i + 1) % StateWords][30:0]};
      fresh = mt_words[(i + ShiftSpan) % StateWords] ^ {1'b0, mixed[31:1]};
      if (mixed[0]) begin
        fresh = fresh ^ TwistMatrix;
      end
      mt_words[i] = fresh;
    end
    next_word = 0;
  endfunction

  function automatic word_t tempered(word_t raw);
    word_t t;
    t = raw ^ {11'b0, raw[31:11]};
    t = t ^ ({t[24:0], 7'b0} & TemperB);
    t = t ^ ({t[16:0], 15'b0} & TemperC);
    return t ^ {18'b0, t[31:18]};
  endfunction

  function automatic word_t next_draw();
    word_t raw;
    if (next_word >= StateWords) begin
      if (next_word == Unseeded) begin
        fill_table(DefaultSeed);
      end
      regenerate_table();
    end
    raw = mt_words[next_word];
    next_word++;
    return tempered(raw);
  endfunction

  function automatic bit shown_failure();
    failures++;
    return failures <= ShownFailures;
  endfunction

  always @(posedge clk) begin
    word_t want;
    if (!rst_n) begin
      next_word = Unseeded;
      predicted_words.delete();
      failures = 0;
      results_seen = 0;
    end else begin
      // Results are checked before the input beat of the same edge is taken,
      // since no draw can return its word in the cycle it is accepted.
      if (out_valid && !out_stall) begin
        results_seen++;
        if (predicted_words.size() == 0) begin
          if (shown_failure()) begin
            $display("Result %0d: word %08h arrived with no draw pending",
                     results_seen, out_random_word);
          end
        end else begin
          want = predicted_words.pop_front();
          if (out_random_word !== want) begin
            if (shown_failure()) begin
              $display("Result %0d: random_word expected %08h, got %08h",
                       results_seen, want, out_random_word);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_func == FuncSeed) begin
          fill_table(in_seed_value);
        end else begin
          predicted_words.push_back(next_draw());
        end
      end
    end
    fail_count    <= failures;
    words_pending <= predicted_words.size();
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the Mersenne Twister generator: a directed opening with the
// unseeded draw, extreme seeds and back-to-back seeds, then random seeded
// runs of draws, some long enough to use up the table, with random gaps and
// stalls on both channels. The checker beside the block judges the results.
// ----------------------------------------------------------------------------

module tb_top;
  import mtg_pkg::*;
  import mtg_tb_pkg::*;

  localparam int ItemTarget    = 1650;
  localparam int IdleLimit     = 20000;
  localparam int SettleCycles  = 100;
  localparam int HoldOffCycles = 400;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_func;
  logic [31:0] in_seed_value;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_random_word;

  int fail_count;
  int words_pending;
  int beats_sent   = 0;
  int idle_cycles  = 0;
  bit steady       = 1'b0;
  bit hold_off_due = 1'b0;

  mersenne_twister_generator DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_seed_value   (in_seed_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_random_word (out_random_word)
  );

  mtg_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_seed_value   (in_seed_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_random_word (out_random_word),
    .fail_count      (fail_count),
    .words_pending   (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_beat(input mt_func_t func, input word_t seed);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= func;
    in_seed_value <= seed;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  initial begin
    int    run_len;
    int    pick;
    word_t seed;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_func       = FuncDraw;
    in_seed_value = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The very first draw has to seed the table with the default seed itself.
    send_beat(FuncDraw, $urandom());
    send_beat(FuncDraw, $urandom());
    send_beat(FuncSeed, 32'h0000_0000);
    send_beat(FuncDraw, $urandom());
    send_beat(FuncDraw, $urandom());
    send_beat(FuncSeed, 32'hFFFF_FFFF);
    send_beat(FuncDraw, $urandom());
    send_beat(FuncSeed, 32'h8000_0000);
    send_beat(FuncSeed, 32'h0000_0001);
    send_beat(FuncDraw, $urandom());
    send_beat(FuncDraw, $urandom());
    // An explicit default seed must replay the unseeded sequence.
    send_beat(FuncSeed, DefaultSeed);
    send_beat(FuncDraw, $urandom());
    send_beat(FuncSeed, 32'h5555_5555);
    send_beat(FuncDraw, $urandom());
    send_beat(FuncSeed, 32'hAAAA_AAAA);
    send_beat(FuncDraw, $urandom());
    send_beat(FuncDraw, $urandom());
    // A seed in mid-table throws away the words not yet drawn.
    send_beat(FuncSeed, $urandom());
    send_beat(FuncDraw, $urandom());

    // One run past the end of the table, with the receiver holding off after
    // the first result so that the block backs up into its input.
    send_beat(FuncSeed, $urandom());
    hold_off_due = 1'b1;
    run_len = StateWords + $urandom_range(4, 40);
    repeat (run_len) send_beat(FuncDraw, $urandom());

    while (beats_sent < ItemTarget) begin
      pick   = $urandom_range(0, 99);
      steady = ($urandom_range(0, 4) == 0);
      if (pick < 8) begin
        send_beat($urandom_range(0, 1) ? FuncSeed : FuncDraw, $urandom());
      end else begin
        case ($urandom_range(0, 7))
          0:       seed = '0;
          1:       seed = '1;
          2:       seed = $urandom_range(0, 255);
          default: seed = $urandom();
        endcase
        send_beat(FuncSeed, seed);
        if (pick < 11) begin
          run_len = $urandom_range(StateWords - 3, StateWords + 30);
        end else begin
          run_len = $urandom_range(1, 40);
        end
        if (run_len > ItemTarget - beats_sent) begin
          run_len = ItemTarget - beats_sent;
        end
        repeat (run_len) send_beat(FuncDraw, $urandom());
      end
    end
    steady = 1'b0;

    in_valid <= 1'b0;
    while (words_pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    int hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_off_due) begin
        hold = HoldOffCycles;
        hold_off_due = 1'b0;
      end else begin
        hold = steady ? 0 : $urandom_range(0, 11);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
